@@ rtl/core/rhms_pkg.sv @@
// Package: shared constants, opcodes and chain entry types for the move sorter.
package rhms_pkg;

  localparam int MOVE_BITS     = 16;
  localparam int SEARCHER_BITS = 2;
  localparam int ADDR_BITS     = MOVE_BITS + SEARCHER_BITS;
  localparam int SCORE_BITS    = 48;
  localparam int COUNT_BITS    = 32;
  localparam int DEPTH_BITS    = 6;
  localparam int MAX_MOVES     = 64;
  localparam int PEND_BITS     = 6;
  localparam int PCNT_BITS     = 7;
  localparam int DIV_CNT_BITS  = 6;

  typedef enum logic [2:0] {
    OP_CLR_SCORE = 3'd0,
    OP_SET_COUNT = 3'd1,
    OP_ADD_SCORE = 3'd2,
    OP_COUNT     = 3'd3,
    OP_LOAD      = 3'd4
  } opcode_t;

  typedef struct packed {
    logic                  valid;
    logic [SCORE_BITS-1:0] key;
    logic [MOVE_BITS-1:0]  move;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

endpackage

@@ rtl/core/rhms_if.sv @@
// Interfaces: request and response channels of the move sorter.
interface rhms_req_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         opcode;
  logic [rhms_pkg::MOVE_BITS-1:0]     move_code;
  logic [rhms_pkg::DEPTH_BITS-1:0]    search_depth;
  logic [rhms_pkg::SEARCHER_BITS-1:0] searcher;
  logic                               last_move;

  modport source (output valid, opcode, move_code, search_depth, searcher, last_move,
                  input ready);
  modport sink (input valid, opcode, move_code, search_depth, searcher, last_move,
                output ready);
endinterface

interface rhms_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [rhms_pkg::MOVE_BITS-1:0] sorted_move;
  logic                           last_out;

  modport source (output valid, sorted_move, last_out, input ready);
  modport sink (input valid, sorted_move, last_out, output ready);
endinterface

@@ rtl/core/rhms_ram.sv @@
// Generic single-port-write, registered-read RAM.
module rhms_ram #(
  parameter int WIDTH = 32,
  parameter int ABITS = 18
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [0:(1 << ABITS)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/rhms_div.sv @@
// Restoring divider: one quotient bit per cycle.
module rhms_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rhms_pkg::SCORE_BITS-1:0] dividend,
  input  logic [rhms_pkg::COUNT_BITS-1:0] divisor,
  output logic                            done,
  output logic [rhms_pkg::SCORE_BITS-1:0] quotient
);
  import rhms_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0]   rem;
  logic [COUNT_BITS-1:0]   dvs;
  logic [COUNT_BITS:0]     rem_sh;
  logic [COUNT_BITS:0]     diff;
  logic                    ge;

  assign rem_sh = {rem, quotient[SCORE_BITS-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= ge ? diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        quotient <= {quotient[SCORE_BITS-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(SCORE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/core/rhms_cell.sv @@
// Sort cell: holds one keyed move, takes inserts and shifts toward the output.
module rhms_cell (
  input  logic                clk,
  input  logic                rst,
  input  rhms_pkg::cell_ctl_t ctl,
  input  rhms_pkg::entry_t    new_ent,
  input  rhms_pkg::entry_t    prev_ent,
  input  logic                prev_greater,
  input  rhms_pkg::entry_t    next_ent,
  output logic                greater,
  output rhms_pkg::entry_t    ent
);
  import rhms_pkg::*;

  // New key goes ahead of this entry; equal keys stay behind (stable order).
  assign greater = !ent.valid || (ent.key < new_ent.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.pop) begin
      ent <= next_ent;
    end else if (ctl.insert && greater) begin
      ent <= prev_greater ? prev_ent : new_ent;
    end
  end
endmodule

@@ rtl/core/relative_history_move_sorter.sv @@
// Relative history move sorter: request channel in, sorted moves out.
//
// req carries one operation per transaction: clear scores, set counts to one,
// add depth squared to a score, add one to a count, or load a move. rsp gives
// the loaded moves, highest score/count first, after a load marked last;
// last_out flags the final move of the run. Ties keep load order.
// Flow: a load that is not last stores its move and stays idle; add and count
// read the table, then write back. Clear and set-to-one sweep 262144 table
// rows, one per cycle. A final load of n moves takes each move in turn
// (pending read, table read, divider, insertion into the cell chain),
// then emits one move per cycle while rsp.ready is high.
// After reset both tables are swept to their initial values before req.ready
// rises. While the receiver stalls the run holds in the chain and no new
// transaction is taken until the last move is delivered.
module relative_history_move_sorter (
  input  logic clk,
  input  logic rst,
  rhms_req_if.sink   req,
  rhms_rsp_if.source rsp
);
  import rhms_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_UPD_WAIT, S_UPD, S_SORT_RD, S_SORT_ADR,
    S_SORT_WAIT, S_SORT_DIVST, S_SORT_DIV, S_EMIT
  } state_t;

  state_t                   state;
  logic                     clr_score;
  logic                     clr_count;
  logic [ADDR_BITS-1:0]     sweep;
  logic [ADDR_BITS-1:0]     tbl_addr;
  logic                     upd_score;
  logic [DEPTH_BITS-1:0]    depth;
  logic [PCNT_BITS-1:0]     pend_count;
  logic [PCNT_BITS-1:0]     pend_count_next;
  logic [PCNT_BITS-1:0]     sort_n;
  logic [PCNT_BITS-1:0]     sort_idx;
  logic [PCNT_BITS-1:0]     emit_left;
  logic [SEARCHER_BITS-1:0] sort_who;
  logic [MOVE_BITS-1:0]     cur_move;
  logic                     div_zero;

  logic [MOVE_BITS-1:0] pending [0:MAX_MOVES-1];
  logic [MOVE_BITS-1:0] pend_q;
  logic                 pend_we;

  logic                  score_we, count_we;
  logic [ADDR_BITS-1:0]  score_wa, count_wa;
  logic [SCORE_BITS-1:0] score_wd, score_q;
  logic [COUNT_BITS-1:0] count_wd, count_q;
  logic [SCORE_BITS:0]   score_sum;
  logic                  accept;

  logic                  div_start, div_done;
  logic [SCORE_BITS-1:0] quot;

  cell_ctl_t ctl;
  entry_t    new_ent;
  entry_t    ents [0:MAX_MOVES-1];
  logic      grt  [0:MAX_MOVES-1];

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign pend_we = accept && (req.opcode == OP_LOAD) && !pend_count[PCNT_BITS-1];
  assign pend_count_next = pend_count + PCNT_BITS'(pend_we);

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pending[pend_count[PEND_BITS-1:0]] <= req.move_code;
    end
    pend_q <= pending[sort_idx[PEND_BITS-1:0]];
  end

  // Table update paths: sweep on clear, read-modify-write on add/count.
  assign score_sum = {1'b0, score_q} + (SCORE_BITS + 1)'(depth * depth);
  assign score_we  = (state == S_CLR && clr_score) || (state == S_UPD && upd_score);
  assign count_we  = (state == S_CLR && clr_count) || (state == S_UPD && !upd_score);
  assign score_wa  = (state == S_CLR) ? sweep : tbl_addr;
  assign count_wa  = score_wa;
  always_comb begin
    if (state == S_CLR) begin
      score_wd = '0;
      count_wd = COUNT_BITS'(1);
    end else begin
      score_wd = score_sum[SCORE_BITS] ? '1 : score_sum[SCORE_BITS-1:0];
      count_wd = (&count_q) ? count_q : count_q + 1'b1;
    end
  end

  rhms_ram #(.WIDTH(SCORE_BITS), .ABITS(ADDR_BITS)) u_score (
    .clk(clk), .we(score_we), .waddr(score_wa), .wdata(score_wd),
    .raddr(tbl_addr), .rdata(score_q)
  );

  rhms_ram #(.WIDTH(COUNT_BITS), .ABITS(ADDR_BITS)) u_count (
    .clk(clk), .we(count_we), .waddr(count_wa), .wdata(count_wd),
    .raddr(tbl_addr), .rdata(count_q)
  );

  assign div_start = (state == S_SORT_DIVST);

  rhms_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(score_q),
    .divisor(count_q), .done(div_done), .quotient(quot)
  );

  assign rsp.valid       = (state == S_EMIT);
  assign rsp.sorted_move = ents[0].move;
  assign rsp.last_out    = (emit_left == PCNT_BITS'(1));

  assign ctl.insert    = (state == S_SORT_DIV) && div_done;
  assign ctl.pop       = rsp.valid && rsp.ready;
  assign new_ent.valid = 1'b1;
  assign new_ent.key   = div_zero ? '0 : quot;
  assign new_ent.move  = cur_move;

  for (genvar i = 0; i < MAX_MOVES; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_g;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_e = ents[i-1];
      assign prev_g = grt[i-1];
    end
    if (i == MAX_MOVES - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = ents[i+1];
    end
    rhms_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .new_ent(new_ent),
      .prev_ent(prev_e), .prev_greater(prev_g), .next_ent(next_e),
      .greater(grt[i]), .ent(ents[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_score  <= 1'b1;
      clr_count  <= 1'b1;
      sweep      <= '0;
      pend_count <= '0;
      sort_idx   <= '0;
      sort_n     <= '0;
      emit_left  <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          sweep <= sweep + 1'b1;
          if (&sweep) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (req.opcode)
              OP_CLR_SCORE: begin
                clr_score <= 1'b1;
                clr_count <= 1'b0;
                sweep     <= '0;
                state     <= S_CLR;
              end
              OP_SET_COUNT: begin
                clr_score <= 1'b0;
                clr_count <= 1'b1;
                sweep     <= '0;
                state     <= S_CLR;
              end
              OP_ADD_SCORE, OP_COUNT: begin
                tbl_addr  <= {req.move_code, req.searcher};
                upd_score <= (req.opcode == OP_ADD_SCORE);
                depth     <= req.search_depth;
                state     <= S_UPD_WAIT;
              end
              OP_LOAD: begin
                pend_count <= pend_count_next;
                if (req.last_move) begin
                  pend_count <= '0;
                  sort_n     <= pend_count_next;
                  sort_idx   <= '0;
                  sort_who   <= req.searcher;
                  if (pend_count_next != '0) begin
                    state <= S_SORT_RD;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_UPD_WAIT: state <= S_UPD;
        S_UPD:      state <= S_IDLE;
        S_SORT_RD:  state <= S_SORT_ADR;
        S_SORT_ADR: begin
          tbl_addr <= {pend_q, sort_who};
          cur_move <= pend_q;
          state    <= S_SORT_WAIT;
        end
        S_SORT_WAIT: state <= S_SORT_DIVST;
        S_SORT_DIVST: begin
          div_zero <= (count_q == '0);
          state    <= S_SORT_DIV;
        end
        S_SORT_DIV: begin
          if (div_done) begin
            sort_idx <= sort_idx + 1'b1;
            if (sort_idx + 1'b1 == sort_n) begin
              emit_left <= sort_n;
              state     <= S_EMIT;
            end else begin
              state <= S_SORT_RD;
            end
          end
        end
        S_EMIT: begin
          if (ctl.pop) begin
            emit_left <= emit_left - 1'b1;
            if (emit_left == PCNT_BITS'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready && rsp.last_out |=> !rsp.valid)
    else $error("output still valid after last move");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend_count <= PCNT_BITS'(MAX_MOVES))
    else $error("pending count beyond list size");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ents[0].valid)
    else $error("emitting from an empty chain");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("request taken during emit");
endmodule

@@ test/tb_relative_history_move_sorter.sv @@
`timescale 1ns / 100ps
// Testbench for the relative history move sorter: directed and random tests, with a score/count predictor.
module tb_relative_history_move_sorter;
  import rhms_pkg::*;

  localparam logic [2:0] OP_NOP_FIRST = 3'd5;
  localparam logic [2:0] OP_NOP_MID   = 3'd6;
  localparam logic [2:0] OP_NOP_LAST  = 3'd7;
  localparam int         STALL_LIMIT  = 1000000;
  localparam logic [SCORE_BITS-1:0] SCORE_SAT = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

  typedef struct {
    logic [MOVE_BITS-1:0] move;
    logic                 last;
  } sorted_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhms_req_if req ();
  rhms_rsp_if rsp ();

  relative_history_move_sorter dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state; missing entries hold their reset values
  logic [SCORE_BITS-1:0] score_of [bit [ADDR_BITS-1:0]];
  logic [COUNT_BITS-1:0] visits_of [bit [ADDR_BITS-1:0]];
  logic [MOVE_BITS-1:0]  pending_list [$];
  sorted_t               sorted_q [$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SCORE_BITS-1:0] rank_of(logic [MOVE_BITS-1:0] mv,
                                                    logic [1:0] who);
    bit [ADDR_BITS-1:0]    a;
    logic [SCORE_BITS-1:0] s;
    logic [COUNT_BITS-1:0] c;
    a = {mv, who};
    s = score_of.exists(a) ? score_of[a] : '0;
    c = visits_of.exists(a) ? visits_of[a] : COUNT_BITS'(1);
    if (c == 0) return '0;
    return s / c;
  endfunction

  task automatic apply_op(logic [2:0] op, logic [15:0] mv, logic [5:0] d,
                          logic [1:0] who, logic lst);
    bit [ADDR_BITS-1:0]    a;
    logic [SCORE_BITS-1:0] s, add;
    logic [SCORE_BITS-1:0] keys [$];
    logic [MOVE_BITS-1:0]  moves [$];
    logic [SCORE_BITS-1:0] k;
    int j;
    sorted_t e;
    a = {mv, who};
    case (op)
      OP_CLR_SCORE: score_of.delete();
      OP_SET_COUNT: visits_of.delete();
      OP_ADD_SCORE: begin
        s = score_of.exists(a) ? score_of[a] : '0;
        add = SCORE_BITS'(d) * SCORE_BITS'(d);
        score_of[a] = (s > SCORE_SAT - add) ? SCORE_SAT : s + add;
      end
      OP_COUNT: begin
        if (!visits_of.exists(a)) visits_of[a] = COUNT_BITS'(1);
        if (visits_of[a] != COUNT_SAT) visits_of[a] = visits_of[a] + 1;
      end
      OP_LOAD: begin
        if (pending_list.size() < MAX_MOVES) pending_list.push_back(mv);
        if (lst) begin
          // stable insertion, descending
          foreach (pending_list[i]) begin
            k = rank_of(pending_list[i], who);
            j = keys.size();
            while (j > 0 && keys[j-1] < k) j--;
            keys.insert(j, k);
            moves.insert(j, pending_list[i]);
          end
          foreach (moves[i]) begin
            e.move = moves[i];
            e.last = (i == moves.size() - 1);
            sorted_q.push_back(e);
          end
          pending_list.delete();
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_op(logic [2:0] op, logic [15:0] mv, logic [5:0] d,
                         logic [1:0] who, logic lst);
    int gap;
    req.valid        <= 1'b1;
    req.opcode       <= op;
    req.move_code    <= mv;
    req.search_depth <= d;
    req.searcher     <= who;
    req.last_move    <= lst;
    do @(posedge clk); while (!req.ready);
    apply_op(op, mv, d, who, lst);
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // response side: random back-pressure
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      stall_left <= pick_gap();
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  sorted_t want;
  always @(posedge clk) begin
    if (rsp.valid && rsp.ready) begin
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected move %h last %b", $time, rsp.sorted_move, rsp.last_out);
        errors++;
      end else begin
        want = sorted_q.pop_front();
        if (rsp.sorted_move !== want.move) begin
          $display("%0t: sorted_move expected %h actual %h", $time, want.move,
                   rsp.sorted_move);
          errors++;
        end
        if (rsp.last_out !== want.last) begin
          $display("%0t: last_out expected %b actual %b", $time, want.last, rsp.last_out);
          errors++;
        end
      end
    end
  end

  // watchdog: covers the table sweeps, during which nothing is accepted
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_scores_and_ties();
    // searcher 1: distinct keys, ties, depth extremes, full-width codes
    send_op(OP_ADD_SCORE, 16'hFFFF, 6'd63, 2'd1, 1'b1);
    send_op(OP_ADD_SCORE, 16'h0000, 6'd10, 2'd1, 1'b0);
    send_op(OP_COUNT,     16'h0000, 6'd0,  2'd1, 1'b0);
    send_op(OP_ADD_SCORE, 16'h1234, 6'd0,  2'd1, 1'b0);
    send_op(OP_ADD_SCORE, 16'h5555, 6'd7,  2'd3, 1'b0);
    send_op(OP_NOP_FIRST, 16'hAAAA, 6'd63, 2'd2, 1'b1);
    send_op(OP_NOP_LAST,  16'h5555, 6'd21, 2'd1, 1'b0);
    send_op(OP_NOP_MID,   16'h0F0F, 6'd42, 2'd0, 1'b1);
    send_op(OP_LOAD, 16'h1234, 6'd0, 2'd0, 1'b0);
    send_op(OP_LOAD, 16'h0000, 6'd0, 2'd2, 1'b0);
    send_op(OP_LOAD, 16'hBEEF, 6'd0, 2'd3, 1'b0);
    send_op(OP_LOAD, 16'h5555, 6'd0, 2'd0, 1'b0);
    send_op(OP_LOAD, 16'hFFFF, 6'd63, 2'd1, 1'b1);
    // two of the same moves keyed by another searcher
    send_op(OP_LOAD, 16'hFFFF, 6'd0, 2'd3, 1'b0);
    send_op(OP_LOAD, 16'h5555, 6'd0, 2'd3, 1'b1);
    // single-move list
    send_op(OP_LOAD, 16'h8001, 6'd0, 2'd2, 1'b1);
  endtask

  task automatic test_full_list();
    // 66 loads: the last two are dropped, the final one still sorts
    for (int i = 0; i < 66; i++)
      send_op(OP_LOAD, 16'($urandom_range(0, 7)), 6'd0, 2'd0, i == 65);
  endtask

  task automatic test_clear_and_reset_counts();
    send_op(OP_CLR_SCORE, 16'h0000, 6'd0, 2'd0, 1'b0);
    send_op(OP_LOAD, 16'hFFFF, 6'd0, 2'd1, 1'b0);
    send_op(OP_LOAD, 16'h0000, 6'd0, 2'd1, 1'b1);
    send_op(OP_ADD_SCORE, 16'h0000, 6'd9, 2'd1, 1'b0);
    send_op(OP_SET_COUNT, 16'hFFFF, 6'd63, 2'd3, 1'b1);
    send_op(OP_LOAD, 16'hFFFF, 6'd0, 2'd1, 1'b0);
    send_op(OP_LOAD, 16'h0000, 6'd0, 2'd1, 1'b1);
  endtask

  task automatic test_random_lists();
    logic [15:0] pool [8];
    int sent, n, r;
    logic [1:0] who;
    sent = 0;
    while (sent < 180) begin
      foreach (pool[i])
        pool[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
      gaps_on = ($urandom_range(0, 3) != 0);
      who = 2'($urandom);
      // warm the tables, then load a list
      repeat ($urandom_range(2, 10)) begin
        r = $urandom_range(0, 19);
        if (r < 10)
          send_op(OP_ADD_SCORE, pool[$urandom_range(0, 7)], 6'($urandom),
                  ($urandom_range(0, 3) == 0) ? 2'($urandom) : who, 1'($urandom));
        else if (r < 18)
          send_op(OP_COUNT, pool[$urandom_range(0, 7)], 6'($urandom), who, 1'($urandom));
        else
          send_op(3'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST)), 16'($urandom),
                  6'($urandom), 2'($urandom), 1'($urandom));
        sent++;
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        send_op(OP_LOAD, pool[$urandom_range(0, 7)], 6'($urandom), 2'($urandom), 1'b0);
        sent++;
      end
      send_op(OP_LOAD, pool[$urandom_range(0, 7)], 6'($urandom), who, 1'b1);
      sent++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    req.valid        <= 1'b0;
    req.opcode       <= OP_LOAD;
    req.move_code    <= '0;
    req.search_depth <= '0;
    req.searcher     <= '0;
    req.last_move    <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_scores_and_ties();
    test_full_list();
    test_clear_and_reset_counts();
    test_random_lists();
    @(posedge clk);
    req.valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
